FILE: rtl/polar_sector_index_assert.svh
// Assertion macros used by the checker of the sector classifier.
`ifndef POLAR_SECTOR_INDEX_ASSERT_SVH
`define POLAR_SECTOR_INDEX_ASSERT_SVH

// same-cycle implication, off during reset
`define PSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define PSI_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/psi_pkg.sv
`default_nettype none

package psi_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS     = 2 * DIFF_BITS;
  localparam int PRESHIFT    = 24;
  localparam int VEC_BITS    = DIFF_BITS + PRESHIFT + 3;
  localparam int COUNT_BITS  = 7;
  localparam int RADIUS_BITS = 16;
  localparam int TURN_BITS   = 16;
  localparam int SECTOR_BITS = 6;
  localparam int ARC_LEN     = 24;

  localparam int DEF_MAX_SECTORS  = 64;
  localparam int DEF_ANGLE_BITS   = 16;
  localparam int DEF_CORDIC_STEPS = 16;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) as a Q32 fraction of a turn
  localparam logic [31:0] ARC_Q32 [ARC_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    REG_SECTOR_COUNT = 2'd0,
    REG_DEAD_RADIUS  = 2'd1,
    REG_START_TURN   = 2'd2
  } psi_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] anchor_x;
    logic signed [COORD_BITS-1:0] anchor_y;
    logic signed [COORD_BITS-1:0] pointer_x;
    logic signed [COORD_BITS-1:0] pointer_y;
  } psi_in_t;

  typedef struct packed {
    logic                   in_dead_zone;
    logic [SECTOR_BITS-1:0] sector;
  } psi_out_t;

  typedef struct packed {
    logic signed [VEC_BITS-1:0] u;
    logic signed [VEC_BITS-1:0] v;
    logic [31:0]                z;
    logic                       zero;
    logic                       dead;
  } psi_vec_t;

  typedef struct packed {
    logic     vld;
    psi_vec_t data;
  } psi_link_t;

endpackage

`default_nettype wire

FILE: rtl/psi_front.sv
`default_nettype none

module psi_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire psi_pkg::psi_in_t          in_data,
  output logic                           in_ready,
  input  wire logic [31:0]               r_sq,
  output psi_pkg::psi_link_t             nxt,
  input  wire logic                      nxt_ready
);

  localparam int DW = psi_pkg::DIFF_BITS;
  localparam int VW = psi_pkg::VEC_BITS;
  localparam int SW = psi_pkg::SQ_BITS;

  // stage A: offsets
  logic                 va;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  // stage B: squares and CORDIC start vector
  logic                 vb;
  logic [SW-1:0]        sx;
  logic [SW-1:0]        sy;
  psi_pkg::psi_vec_t    vec_b;
  // stage C: dead-zone compare
  logic                 vc;
  psi_pkg::psi_vec_t    vec_c;

  logic ready_a, ready_b, ready_c;

  logic signed [DW-1:0]   dx_next, dy_next;
  logic signed [2*DW-1:0] sx_next, sy_next;
  logic signed [VW-1:0]   u_init, v_init;
  psi_pkg::psi_vec_t      vec_b_next;
  psi_pkg::psi_vec_t      vec_c_next;
  logic [SW-1:0]          d_sq;

  assign ready_c  = !vc || nxt_ready;
  assign ready_b  = !vb || ready_c;
  assign ready_a  = !va || ready_b;
  assign in_ready = ready_a;

  assign dx_next = DW'(in_data.pointer_x) - DW'(in_data.anchor_x);
  assign dy_next = DW'(in_data.pointer_y) - DW'(in_data.anchor_y);

  assign sx_next = dx * dx;
  assign sy_next = dy * dy;

  // start at (-dy, dx); flip into the right half plane
  assign u_init = -(VW'(dy) <<< psi_pkg::PRESHIFT);
  assign v_init = VW'(dx) <<< psi_pkg::PRESHIFT;

  always_comb begin
    vec_b_next.zero = (dx == '0) && (dy == '0);
    vec_b_next.dead = 1'b0;
    if (u_init[VW-1]) begin
      vec_b_next.u = -u_init;
      vec_b_next.v = -v_init;
      vec_b_next.z = psi_pkg::HALF_TURN;
    end else begin
      vec_b_next.u = u_init;
      vec_b_next.v = v_init;
      vec_b_next.z = '0;
    end
  end

  assign d_sq = sx + sy;

  always_comb begin
    vec_c_next      = vec_b;
    vec_c_next.dead = d_sq < SW'(r_sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (ready_a) va <= in_valid;
      if (ready_b) vb <= va;
      if (ready_c) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      dx <= dx_next;
      dy <= dy_next;
    end
    if (ready_b) begin
      sx    <= SW'(sx_next);
      sy    <= SW'(sy_next);
      vec_b <= vec_b_next;
    end
    if (ready_c) vec_c <= vec_c_next;
  end

  assign nxt.vld  = vc;
  assign nxt.data = vec_c;

endmodule

`default_nettype wire

FILE: rtl/psi_cell.sv
`default_nettype none

module psi_cell #(
  parameter int STEP = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire psi_pkg::psi_link_t prev,
  output logic                    prev_ready,
  output psi_pkg::psi_link_t      nxt,
  input  wire logic               nxt_ready
);

  localparam int VW = psi_pkg::VEC_BITS;
  localparam logic [31:0] ARC = psi_pkg::ARC_Q32[STEP];

  logic                 vld;
  psi_pkg::psi_vec_t    vec;
  psi_pkg::psi_vec_t    vec_next;
  logic signed [VW-1:0] us, vs;

  assign prev_ready = !vld || nxt_ready;

  assign us = prev.data.u >>> STEP;
  assign vs = prev.data.v >>> STEP;

  // rotate toward the u axis, both updates from the old vector
  always_comb begin
    vec_next = prev.data;
    if (!prev.data.v[VW-1]) begin
      vec_next.u = prev.data.u + vs;
      vec_next.v = prev.data.v - us;
      vec_next.z = prev.data.z + ARC;
    end else begin
      vec_next.u = prev.data.u - vs;
      vec_next.v = prev.data.v + us;
      vec_next.z = prev.data.z - ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (prev_ready) begin
      vld <= prev.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_ready) vec <= vec_next;
  end

  assign nxt.vld  = vld;
  assign nxt.data = vec;

endmodule

`default_nettype wire

FILE: rtl/psi_back.sv
`default_nettype none

module psi_back #(
  parameter int MAX_SECTORS = psi_pkg::DEF_MAX_SECTORS,
  parameter int ANGLE_BITS  = psi_pkg::DEF_ANGLE_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire psi_pkg::psi_link_t                  prev,
  output logic                                     prev_ready,
  input  wire logic [psi_pkg::COUNT_BITS-1:0]      sector_count,
  input  wire logic [psi_pkg::TURN_BITS-1:0]       start_turn,
  output logic                                     out_valid,
  output psi_pkg::psi_out_t                        out_data,
  input  wire logic                                out_stall
);

  localparam int CW = psi_pkg::COUNT_BITS;
  localparam int PW = ANGLE_BITS + CW;

  logic                  v1, v2, v3;
  logic                  ready1, ready2, ready3;
  logic [ANGLE_BITS-1:0] rel1;
  logic [CW-1:0]         cnt1, cnt2;
  logic                  dead1, dead2;
  logic [CW-1:0]         idx2;
  psi_pkg::psi_out_t     res;

  logic [31:0]           z_round;
  logic [ANGLE_BITS-1:0] angle;
  logic [ANGLE_BITS-1:0] start;
  logic [CW-1:0]         cnt;
  logic [PW-1:0]         prod;
  logic [CW-1:0]         idx_clamp;
  psi_pkg::psi_out_t     res_next;

  assign ready3     = !v3 || !out_stall;
  assign ready2     = !v2 || ready3;
  assign ready1     = !v1 || ready2;
  assign prev_ready = ready1;

  // round to nearest, half up, modulo one turn
  assign z_round = prev.data.z + (32'd1 << (31 - ANGLE_BITS));
  assign angle   = prev.data.zero ? '0 : z_round[31 -: ANGLE_BITS];

  // scale the 16-bit start to the angle width
  assign start = ANGLE_BITS'({start_turn, 8'h00} >> (24 - ANGLE_BITS));

  always_comb begin
    if (sector_count == '0) begin
      cnt = CW'(1);
    end else if ({2'b00, sector_count} > 9'(MAX_SECTORS)) begin
      cnt = CW'(MAX_SECTORS);
    end else begin
      cnt = sector_count;
    end
  end

  assign prod = PW'(rel1) * PW'(cnt1);

  assign idx_clamp = (idx2 >= cnt2) ? cnt2 - CW'(1) : idx2;

  always_comb begin
    res_next.in_dead_zone = dead2;
    res_next.sector       = dead2 ? '0 : idx_clamp[psi_pkg::SECTOR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= prev.vld;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      rel1  <= angle - start;
      cnt1  <= cnt;
      dead1 <= prev.data.dead;
    end
    if (ready2) begin
      idx2  <= prod[ANGLE_BITS +: CW];
      cnt2  <= cnt1;
      dead2 <= dead1;
    end
    if (ready3) res <= res_next;
  end

  assign out_valid = v3;
  assign out_data  = res;

endmodule

`default_nettype wire

FILE: rtl/polar_sector_index.sv
// Pointer sector classifier.
// Input channel in_valid/in_stall/in_data carries one request: a center point and
// a pointer point in signed 1/16-pixel screen units. Output channel
// out_valid/out_stall/out_data returns one result per request, in order:
// in_dead_zone, and the sector index clockwise from the start angle (zero up).
// Registers over the APB port: 0x0 sector_count, 0x4 dead_radius, 0x8 start_turn;
// write them only while no request is in flight.
// The chain has three front stages (offset, squares, dead-zone compare), one
// CORDIC cell per step, and three back stages (round and subtract start,
// multiply by count, clamp into the output register). Throughput is one
// request per cycle while out_stall is low; every stage holds its own valid
// bit, so bubbles close up when the output is stalled and the block keeps
// taking requests until the whole chain is full.
// When out_stall is high the result in the output register holds and
// in_stall rises only once no stage has room left.
// Synchronous reset empties the chain and sets sector_count to 1,
// dead_radius and start_turn to 0.
`default_nettype none

module polar_sector_index #(
  parameter int MAX_SECTORS  = psi_pkg::DEF_MAX_SECTORS,
  parameter int ANGLE_BITS   = psi_pkg::DEF_ANGLE_BITS,
  parameter int CORDIC_STEPS = psi_pkg::DEF_CORDIC_STEPS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire psi_pkg::psi_in_t  in_data,
  output logic                   in_stall,
  output logic                   out_valid,
  output psi_pkg::psi_out_t      out_data,
  input  wire logic              out_stall,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [psi_pkg::COUNT_BITS-1:0]  sector_count;
  logic [psi_pkg::RADIUS_BITS-1:0] dead_radius;
  logic [psi_pkg::TURN_BITS-1:0]   start_turn;
  logic [31:0]                     r_sq;
  psi_pkg::psi_reg_t               reg_sel;
  logic                            wr_en;
  logic                            front_ready;

  psi_pkg::psi_link_t chain [CORDIC_STEPS+1];
  logic               rdy   [CORDIC_STEPS+1];

  assign pready  = 1'b1;
  assign reg_sel = psi_pkg::psi_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count <= psi_pkg::COUNT_BITS'(1);
      dead_radius  <= '0;
      start_turn   <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        psi_pkg::REG_SECTOR_COUNT: sector_count <= pwdata[psi_pkg::COUNT_BITS-1:0];
        psi_pkg::REG_DEAD_RADIUS:  dead_radius  <= pwdata[psi_pkg::RADIUS_BITS-1:0];
        psi_pkg::REG_START_TURN:   start_turn   <= pwdata[psi_pkg::TURN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      psi_pkg::REG_SECTOR_COUNT: prdata = 32'(sector_count);
      psi_pkg::REG_DEAD_RADIUS:  prdata = 32'(dead_radius);
      psi_pkg::REG_START_TURN:   prdata = 32'(start_turn);
      default:                   prdata = '0;
    endcase
  end

  // squared radius, ready well before a request reaches the compare
  always_ff @(posedge clk) begin
    r_sq <= dead_radius * dead_radius;
  end

  assign in_stall = !front_ready;

  psi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (front_ready),
    .r_sq      (r_sq),
    .nxt       (chain[0]),
    .nxt_ready (rdy[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    psi_cell #(
      .STEP (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .prev       (chain[k]),
      .prev_ready (rdy[k]),
      .nxt        (chain[k+1]),
      .nxt_ready  (rdy[k+1])
    );
  end

  psi_back #(
    .MAX_SECTORS (MAX_SECTORS),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .prev         (chain[CORDIC_STEPS]),
    .prev_ready   (rdy[CORDIC_STEPS]),
    .sector_count (sector_count),
    .start_turn   (start_turn),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_stall    (out_stall)
  );

endmodule

`default_nettype wire

FILE: rtl/psi_checker.sv
`default_nettype none
`include "polar_sector_index_assert.svh"

module psi_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire psi_pkg::psi_out_t out_data
);

  logic held;
  logic dead_out;

  assign held     = out_valid && out_stall;
  assign dead_out = out_valid && out_data.in_dead_zone;

  `PSI_ASSERT_NEXT(a_out_hold, held, out_valid, "result dropped under stall")
  `PSI_ASSERT_NEXT(a_out_stable, held, $stable(out_data), "result changed under stall")
  `PSI_ASSERT_NOW(a_dead_sector, dead_out, out_data.sector == '0, "sector set in dead zone")
  `PSI_ASSERT_RST(a_reset_empty, rst, !out_valid, "result shown right after reset")

endmodule

bind polar_sector_index psi_checker u_psi_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
